// File: rtl/ttl_cache_table_top_defines.svh
// Assertion macros shared by the ttl cache table RTL.
// Expects clk and rst in the scope of each use.
`ifndef TTL_CACHE_TABLE_TOP_DEFINES_SVH
`define TTL_CACHE_TABLE_TOP_DEFINES_SVH

// Clocked check, muted while reset is high
`define TTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define TTL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ttl_pkg.sv
// Package for the ttl cache table: sizes, status codes and request/result types.
// No dependencies; imported by ttl_cache_table_top.
package ttl_pkg;

  // Table geometry
  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 64;
  localparam int DATA_BITS = 64;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Fixed port field widths
  localparam int KEY_W    = 64;
  localparam int PAY_W    = 64;
  localparam int TIME_W   = 32;
  localparam int TTL_W    = 24;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int OCC_W    = 5;

  localparam logic [TTL_W-1:0] TTL_DEFAULT = TTL_W'(300);

  // Operation codes
  localparam logic MODE_STORE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd4;

  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [TIME_W-1:0] now;
  } ttl_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAY_W-1:0]    data_out;
    logic [SLOT_W-1:0]   slot;
    logic [OCC_W-1:0]    occupancy;
  } ttl_rsp_t;

endpackage

// File: rtl/ttl_cache_table_top.sv
// Fully associative TTL cache table with a sequential slot scanner.
// Depends on ttl_pkg and ttl_cache_table_top_defines.svh.
//
//  channel   handshake             payload    direction
//  request   start / busy          req        in
//  result    done (strobe)         rsp        out
//  config    cfg_valid / cfg_ready cfg_data   in
//
// A request scans the slots: one slot read per cycle from the entry
// memory, a compare stage behind it, then the write-back in S_DONE;
// a key match ends the scan early.
// busy is high from the accepting edge until the result strobe cycle.
// rst is synchronous; it clears the valid bits and the count, and sets the TTL to TTL_DEFAULT.
// The result strobe lasts one cycle and cannot be held off; config waits for idle.
`include "ttl_cache_table_top_defines.svh"

module ttl_cache_table_top
  import ttl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ttl_req_t         req,
  output logic             done,
  output ttl_rsp_t         rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TTL_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;

  // Entry memories
  logic [KEY_BITS-1:0]  mem_key     [ENTRIES];
  logic [DATA_BITS-1:0] mem_data    [ENTRIES];
  logic [TIME_W-1:0]    mem_created [ENTRIES];
  logic [TTL_W-1:0]     mem_life    [ENTRIES];

  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   count;
  logic [TTL_W-1:0]   ttl;

  ttl_req_t cur;

  // Scan pipeline
  logic [CNT_W-1:0]     rd_cnt;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic [KEY_BITS-1:0]  rd_key;
  logic [DATA_BITS-1:0] rd_data;
  logic [TIME_W-1:0]    rd_created;
  logic [TTL_W-1:0]     rd_life;

  logic             match_hit;
  logic [IDX_W-1:0] match_idx;
  logic             vic_done;
  logic             vic_found;
  logic [IDX_W-1:0] vic_idx;
  logic [TIME_W-1:0] oldest;

  logic hit_now;
  logic last_cmp;
  logic issue;
  logic cmp_entry_valid;

  // Write-back decision
  logic [IDX_W-1:0]    wr_idx;
  logic                set_valid;
  logic                clr_valid;
  logic [CNT_W-1:0]    count_next;
  logic [STATUS_W-1:0] status_next;
  logic [DATA_BITS-1:0] data_next;
  logic [IDX_W-1:0]    slot_idx;
  logic [TIME_W-1:0]   age;
  logic                expired;

  logic [PAY_W+DATA_BITS-1:0] data_ext;
  logic [SLOT_W+IDX_W-1:0]    slot_ext;
  logic [OCC_W+CNT_W-1:0]     occ_ext;

  assign busy      = (state != S_IDLE);
  // Hold config writes off while a request is accepted or in flight
  assign cfg_ready = (state == S_IDLE) && !start;

  // Compare stage against the slot read last cycle
  assign cmp_entry_valid = valid[cmp_idx];
  assign hit_now  = (state == S_SCAN) && cmp_vld && cmp_entry_valid &&
                    (rd_key == cur.key[KEY_BITS-1:0]);
  assign last_cmp = cmp_vld && (cmp_idx == IDX_W'(ENTRIES - 1));
  assign issue    = (state == S_SCAN) && (rd_cnt < CNT_W'(ENTRIES)) && !hit_now;

  // Age check of the matched entry; its read data stays frozen after the hit
  assign age     = cur.now - rd_created;
  assign expired = $signed({age[TIME_W-1], age}) >
                   $signed({{(TIME_W + 1 - TTL_W){1'b0}}, rd_life});

  // Decide write-back, status and new occupancy
  always_comb begin
    wr_idx      = vic_found ? vic_idx : '0;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    count_next  = count;
    status_next = ST_MISS;
    data_next   = '0;
    slot_idx    = '0;
    if (cur.mode == MODE_STORE) begin
      if (match_hit) begin
        wr_idx      = match_idx;
        status_next = ST_UPDATED;
      end else begin
        set_valid   = 1'b1;
        status_next = ST_INSERTED;
        if (!valid[wr_idx]) begin
          count_next = count + 1'b1;
        end
      end
      slot_idx = wr_idx;
    end else if (match_hit) begin
      slot_idx = match_idx;
      if (expired) begin
        clr_valid   = 1'b1;
        status_next = ST_EXPIRED;
        if (count != '0) begin
          count_next = count - 1'b1;
        end
      end else begin
        status_next = ST_HIT;
        data_next   = rd_data;
      end
    end
  end

  assign data_ext = {{PAY_W{1'b0}}, data_next};
  assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};
  assign occ_ext  = {{OCC_W{1'b0}}, count_next};

  // Sequencer, scan bookkeeping and table control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      count     <= '0;
      ttl       <= TTL_DEFAULT;
      done      <= 1'b0;
      cmp_vld   <= 1'b0;
      rd_cnt    <= '0;
      match_hit <= 1'b0;
      vic_done  <= 1'b0;
      vic_found <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_valid && cfg_ready) begin
        ttl <= (cfg_data == '0) ? TTL_DEFAULT : cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state     <= S_SCAN;
            rd_cnt    <= '0;
            cmp_vld   <= 1'b0;
            match_hit <= 1'b0;
            vic_done  <= 1'b0;
            vic_found <= 1'b0;
          end
        end
        S_SCAN: begin
          cmp_vld <= issue;
          if (issue) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          // Track the victim: first free slot, else oldest strictly below now
          if (cmp_vld && !vic_done) begin
            if (!cmp_entry_valid) begin
              vic_done  <= 1'b1;
              vic_found <= 1'b1;
            end else if (rd_created < oldest) begin
              vic_found <= 1'b1;
            end
          end
          if (hit_now) begin
            match_hit <= 1'b1;
            state     <= S_DONE;
          end else if (last_cmp) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (set_valid) begin
            valid[wr_idx] <= 1'b1;
          end
          if (clr_valid) begin
            valid[match_idx] <= 1'b0;
          end
          count <= count_next;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request, scan indexes, victim time, result
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      cur    <= req;
      oldest <= req.now;
    end
    if (issue) begin
      cmp_idx <= rd_cnt[IDX_W-1:0];
    end
    if ((state == S_SCAN) && cmp_vld && !vic_done) begin
      if (!cmp_entry_valid || (rd_created < oldest)) begin
        vic_idx <= cmp_idx;
      end
      if (cmp_entry_valid && (rd_created < oldest)) begin
        oldest <= rd_created;
      end
    end
    if (hit_now) begin
      match_idx <= cmp_idx;
    end
    if (state == S_DONE) begin
      rsp.status    <= status_next;
      rsp.data_out  <= data_ext[PAY_W-1:0];
      rsp.slot      <= slot_ext[SLOT_W-1:0];
      rsp.occupancy <= occ_ext[OCC_W-1:0];
    end
  end

  // Entry memory: one read port for the scan, one write port for write-back
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_key     <= mem_key[rd_cnt[IDX_W-1:0]];
      rd_data    <= mem_data[rd_cnt[IDX_W-1:0]];
      rd_created <= mem_created[rd_cnt[IDX_W-1:0]];
      rd_life    <= mem_life[rd_cnt[IDX_W-1:0]];
    end
    if ((state == S_DONE) && (cur.mode == MODE_STORE)) begin
      mem_key[wr_idx]     <= cur.key[KEY_BITS-1:0];
      mem_data[wr_idx]    <= cur.payload[DATA_BITS-1:0];
      mem_created[wr_idx] <= cur.now;
      mem_life[wr_idx]    <= ttl;
    end
  end

  // Checks
  `TTL_ASSERT(a_count_matches_valid, $countones(valid) == count, "occupancy count drifted from valid bits")
  `TTL_ASSERT(a_done_after_writeback, done |-> $past(state == S_DONE), "result strobe without write-back")
  `TTL_ASSERT(a_busy_after_accept, (start && !busy) |=> busy, "request accepted but block not busy")
  `TTL_ASSERT_ALWAYS(a_count_bounded, rst || (count <= CNT_W'(ENTRIES)), "occupancy above table size")

endmodule

// File: verif/ttl_cache_table_top_tb.sv
// Self-checking testbench for ttl_cache_table_top: stores and lookups against a
// built-in table predictor, TTL register changes between phases.
// Depends on ttl_pkg and the ttl_cache_table_top RTL.
module ttl_cache_table_top_tb;
  import ttl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SIZE   = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  ttl_req_t         req = '0;
  logic             done;
  ttl_rsp_t         rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TTL_W-1:0] cfg_data = '0;

  // Predicted table contents
  logic              tbl_valid [ENTRIES];
  logic [KEY_W-1:0]  tbl_key [ENTRIES];
  logic [PAY_W-1:0]  tbl_data [ENTRIES];
  logic [TIME_W-1:0] tbl_born [ENTRIES];
  logic [TTL_W-1:0]  tbl_life [ENTRIES];
  logic [OCC_W-1:0]  tbl_count;
  logic [TTL_W-1:0]  cur_lifetime;

  ttl_rsp_t          pending_rsp [$];
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  logic [TIME_W-1:0] cur_now;
  int                burst_left = 0;
  int                errors = 0;
  int                cycles = 0;
  int                n_requests = 0;
  int                n_status [8];

  ttl_cache_table_top uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding",
               $time, cycles, pending_rsp.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Apply one request to the predicted table and return the expected result
  function automatic ttl_rsp_t apply_request(ttl_req_t r);
    ttl_rsp_t          res;
    int                hit_idx;
    int                victim;
    logic [TIME_W-1:0] oldest;
    int                age;

    res = '0;
    hit_idx = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_idx < 0 && tbl_valid[i] && tbl_key[i] == r.key) hit_idx = i;
    end

    if (r.mode == MODE_STORE) begin
      if (hit_idx >= 0) begin
        victim = hit_idx;
        res.status = ST_UPDATED;
      end else begin
        // first empty slot, else oldest strictly below now, else slot 0
        victim = -1;
        oldest = r.now;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!tbl_valid[i]) begin
            victim = i;
            break;
          end
          if (tbl_born[i] < oldest) begin
            oldest = tbl_born[i];
            victim = i;
          end
        end
        if (victim < 0) victim = 0;
        if (!tbl_valid[victim]) tbl_count++;
        tbl_valid[victim] = 1'b1;
        tbl_key[victim] = r.key;
        res.status = ST_INSERTED;
      end
      tbl_data[victim] = r.payload;
      tbl_born[victim] = r.now;
      tbl_life[victim] = cur_lifetime;
      res.slot = SLOT_W'(victim);
    end else if (hit_idx < 0) begin
      res.status = ST_MISS;
    end else begin
      // age is the wrapped difference read as signed; negative never expires
      age = int'(r.now - tbl_born[hit_idx]);
      res.slot = SLOT_W'(hit_idx);
      if (age > int'(tbl_life[hit_idx])) begin
        tbl_valid[hit_idx] = 1'b0;
        if (tbl_count != 0) tbl_count--;
        res.status = ST_EXPIRED;
      end else begin
        res.data_out = tbl_data[hit_idx];
        res.status = ST_HIT;
      end
    end
    res.occupancy = tbl_count;
    return res;
  endfunction

  // Present one request and hold it until accepted; start stays high
  task automatic send_request(ttl_req_t r);
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(apply_request(r));
    n_requests++;
  endtask

  task automatic issue(logic mode, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                       logic [TIME_W-1:0] t);
    ttl_req_t r;
    r.mode = mode;
    r.key = k;
    r.payload = p;
    r.now = t;
    send_request(r);
  endtask

  // Drop start and hold until every expected result has arrived
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  // Write the lifetime register with the table idle
  task automatic write_lifetime(logic [TTL_W-1:0] value);
    drain_results();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_lifetime = (value == '0) ? TTL_DEFAULT : value;
  endtask

  // Bursts of back-to-back requests separated by random gaps
  task automatic pace_sender();
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Random traffic over a small key pool so that hits, updates and evictions occur
  task automatic run_traffic(int count, int unsigned step_max, logic [TIME_W-1:0] t0);
    ttl_req_t r;
    int       sel;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand64();
    if ($urandom_range(0, 1) == 1) begin
      key_pool[0] = '0;
      key_pool[1] = '1;
    end
    cur_now = t0;
    for (int n = 0; n < count; n++) begin
      pace_sender();
      sel = $urandom_range(0, 99);
      r.mode = ($urandom_range(0, 1) == 0) ? MODE_STORE : MODE_LOOKUP;
      r.payload = rand64();
      if (sel < 85) begin
        r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        cur_now = cur_now + TIME_W'($urandom_range(0, step_max));
        r.now = cur_now;
      end else if (sel < 93) begin
        r.key = rand64();
        r.now = $urandom;
      end else begin
        // time running backwards gives negative ages
        r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        r.now = cur_now - TIME_W'($urandom_range(1, step_max * 4 + 1));
      end
      send_request(r);
    end
  endtask

  // Miss on empty table, key and payload extremes, boundary age, expiry, wrap
  task automatic test_basic_ops();
    issue(MODE_LOOKUP, 64'd5, rand64(), 32'd100);
    issue(MODE_STORE, '0, '0, 32'd0);
    issue(MODE_STORE, '1, '1, 32'hFFFF_FFFF);
    issue(MODE_LOOKUP, '1, '0, 32'hFFFF_FFFF);
    issue(MODE_STORE, '0, 64'hA5A5_5A5A_F00D_0FF0, 32'd10);
    issue(MODE_LOOKUP, '0, '1, 32'd310);
    issue(MODE_LOOKUP, '0, '0, 32'd311);
    issue(MODE_LOOKUP, '0, '0, 32'd312);
    issue(MODE_LOOKUP, '1, '0, 32'd5);
    issue(MODE_LOOKUP, '1, '0, 32'hFFFF_FF00);
  endtask

  // Fill the table, evict the oldest, then evict with nothing older than now
  task automatic test_replacement();
    for (int i = 0; i < ENTRIES - 1; i++)
      issue(MODE_STORE, 64'd100 + i, rand64(), 32'd1000 + ((i * 7) % 15));
    issue(MODE_STORE, 64'd200, rand64(), 32'd2000);
    issue(MODE_STORE, 64'd300, rand64(), 32'd0);
  endtask

  task automatic test_short_lifetime();
    write_lifetime(24'd8);
    run_traffic(110, 3, 32'd5000);
  endtask

  task automatic test_time_wrap();
    write_lifetime(24'd1);
    run_traffic(110, 1, 32'hFFFF_FF80);
  endtask

  task automatic test_long_lifetime();
    write_lifetime(24'hFF_FFFF);
    run_traffic(110, 1000000, $urandom);
  endtask

  // A zero write falls back to the default lifetime
  task automatic test_default_lifetime();
    write_lifetime(24'd0);
    run_traffic(110, 60, $urandom);
  endtask

  task automatic test_mixed_with_drain();
    write_lifetime(TTL_W'($urandom_range(2, 100)));
    run_traffic(55, 20, $urandom);
    drain_results();
    run_traffic(55, 20, cur_now);
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    ttl_rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result: status %0d data %h slot %0d occ %0d",
                 $time, rsp.status, rsp.data_out, rsp.slot, rsp.occupancy);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        n_status[want.status]++;
        if (rsp.status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, want.status, rsp.status);
          errors++;
        end
        if (rsp.data_out !== want.data_out) begin
          $display("%0t data_out mismatch: expected %h actual %h",
                   $time, want.data_out, rsp.data_out);
          errors++;
        end
        if (rsp.slot !== want.slot) begin
          $display("%0t slot mismatch: expected %0d actual %0d",
                   $time, want.slot, rsp.slot);
          errors++;
        end
        if (rsp.occupancy !== want.occupancy) begin
          $display("%0t occupancy mismatch: expected %0d actual %0d",
                   $time, want.occupancy, rsp.occupancy);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_data[i] = '0;
      tbl_born[i] = '0;
      tbl_life[i] = '0;
    end
    for (int i = 0; i < 8; i++) n_status[i] = 0;
    tbl_count = '0;
    cur_lifetime = TTL_DEFAULT;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_replacement();
    test_short_lifetime();
    test_time_wrap();
    test_long_lifetime();
    test_default_lifetime();
    test_mixed_with_drain();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests: %0d updated, %0d inserted, %0d hit, %0d miss, %0d expired",
             n_requests, n_status[ST_UPDATED], n_status[ST_INSERTED], n_status[ST_HIT],
             n_status[ST_MISS], n_status[ST_EXPIRED]);
    $display("lifetimes 1, 8, 300 (zero write), max and random; time wrap; %0d errors",
             errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ttl_pkg.sv
rtl/ttl_cache_table_top.sv
verif/ttl_cache_table_top_tb.sv
